@@ hw/rtl/a4e_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a4e_pkg
// Shared widths, limits, step scale table and result structs for the 4-bit
// ADPCM encoder.
// ----------------------------------------------------------------------------
package a4e_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PRED_W   = 16;
    localparam int MAG_W    = 16;
    localparam int STEP_W   = 15;
    localparam int CODE_W   = 4;
    localparam int BYTE_W   = 8;

    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

    // quotient unit: three restoring steps give the 3-bit magnitude
    localparam int QUANT_STEPS = 3;
    localparam int QCNT_W      = $clog2(QUANT_STEPS);

    // radix-4 shift-add multiplier
    localparam int MUL_A_W   = 10;
    localparam int MUL_B_W   = 15;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_A_W / 2;
    localparam int MCNT_W    = $clog2(MUL_STEPS);

    typedef struct packed {
        logic       done;
        logic [2:0] mag;
    } quant_res_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_res_t;

    function automatic logic [MUL_A_W-1:0] step_scale(input logic [2:0] m);
        logic [MUL_A_W-1:0] s;
        case (m)
            3'd4:    s = 10'd307;
            3'd5:    s = 10'd409;
            3'd6:    s = 10'd512;
            3'd7:    s = 10'd614;
            default: s = 10'd230;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/a4e_pcm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a4e_pcm_if
// Sample channel: valid/ready handshake carrying one PCM sample per item.
// ----------------------------------------------------------------------------
interface a4e_pcm_if;
    logic                          valid;
    logic                          ready;
    logic [a4e_pkg::SAMPLE_W-1:0]  sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/a4e_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a4e_byte_if
// Code channel: valid/ready handshake carrying one packed code byte per item.
// ----------------------------------------------------------------------------
interface a4e_byte_if;
    logic                        valid;
    logic                        ready;
    logic [a4e_pkg::BYTE_W-1:0]  packed_byte;
    logic                        stream_end;

    modport source (output valid, output packed_byte, output stream_end, input ready);
    modport sink   (input valid, input packed_byte, input stream_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/adpcm_4bit_encoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_4bit_encoder_unit
// Step-adaptive 4-bit ADPCM encoder, two codes packed per output byte.
// ----------------------------------------------------------------------------
// Usage:
//   pcm   : input items, one signed 16-bit sample each; last marks the final
//           sample of a stream.
//   adpcm : output items, one packed byte each, earlier code in the low nibble.
//           stream_end flags the final byte of a stream.
//   A byte leaves after every second sample, and after a last sample on an odd
//   count (high nibble zero). The predictor, step and nibble pairing restart
//   after each last sample.
//   A new sample is taken only once the previous one is through. Each sample runs
//   through the 3-step bit-serial quotient unit, then through the 5-step radix-4
//   multipliers that form the predictor delta and the next step size.
//   An accepted sample passes the DIFF, QLOAD, QUANT and MUL states; the byte is
//   loaded into the output register as MUL ends when that register is free.
//   A finished byte sits in the output register; pcm takes the next item
//   meanwhile. If the byte after that is done while the receiver still stalls,
//   the encoder holds it and waits with pcm.ready low.
//   Reset (rst_n low, asynchronous) clears the predictor to 0, the step to 127
//   and empties the output register.
// ----------------------------------------------------------------------------
module adpcm_4bit_encoder_unit (
    input wire logic   clk,
    input wire logic   rst_n,
    a4e_pcm_if.sink    pcm,
    a4e_byte_if.source adpcm
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_QLOAD = 3'd2;
    localparam logic [2:0] ST_QUANT = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [a4e_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         last_reg;
    logic [a4e_pkg::MAG_W-1:0]    mag_reg;
    logic                         sign_reg;
    logic [2:0]                   m_reg;

    logic [a4e_pkg::PRED_W-1:0]   pred_reg;
    logic [a4e_pkg::PRED_W-1:0]   pred_next;
    logic [a4e_pkg::STEP_W-1:0]   step_reg;
    logic [a4e_pkg::STEP_W-1:0]   step_next;
    logic [a4e_pkg::CODE_W-1:0]   held_reg;
    logic [a4e_pkg::CODE_W-1:0]   held_next;
    logic                         phase_reg;
    logic                         phase_next;

    logic [a4e_pkg::BYTE_W-1:0]   res_byte_reg;
    logic [a4e_pkg::BYTE_W-1:0]   res_byte_next;
    logic                         res_end_reg;
    logic                         res_end_next;

    logic                         out_valid_reg;
    logic [a4e_pkg::BYTE_W-1:0]   out_byte_reg;
    logic [a4e_pkg::BYTE_W-1:0]   out_byte_next;
    logic                         out_end_reg;
    logic                         out_end_next;
    logic                         load_out;
    logic                         out_free;

    logic                         accept;
    logic                         q_start;
    a4e_pkg::quant_res_t          q_res;
    a4e_pkg::mul_res_t            d_res;
    a4e_pkg::mul_res_t            s_res;

    logic [a4e_pkg::SAMPLE_W:0]   diff;
    logic [a4e_pkg::SAMPLE_W:0]   diff_neg;

    logic [a4e_pkg::CODE_W-1:0]   code;
    logic [15:0]                  d_raw;
    logic [14:0]                  d_cl;
    logic [a4e_pkg::PRED_W:0]     nv;
    logic [a4e_pkg::PRED_W-1:0]   nv_cl;
    logic [16:0]                  ns_raw;
    logic [a4e_pkg::STEP_W-1:0]   ns_cl;
    logic [a4e_pkg::BYTE_W-1:0]   upd_byte;
    logic                         upd_need;

    assign accept    = pcm.valid && pcm.ready;
    assign pcm.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || adpcm.ready;

    assign adpcm.valid       = out_valid_reg;
    assign adpcm.packed_byte = out_byte_reg;
    assign adpcm.stream_end  = out_end_reg;

    // sample with low 3 bits cleared, minus predictor
    assign diff     = {sample_reg[a4e_pkg::SAMPLE_W-1], sample_reg[a4e_pkg::SAMPLE_W-1:3], 3'b000}
                    - {pred_reg[a4e_pkg::PRED_W-1], pred_reg};
    assign diff_neg = '0 - diff;

    a4e_quant u_quant (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_start),
        .mag   (mag_reg),
        .step  (step_reg),
        .res   (q_res)
    );

    // delta = ((1 + 2m) * step) >> 3
    a4e_mul u_mul_delta (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_res.done),
        .a     ({{(a4e_pkg::MUL_A_W-4){1'b0}}, q_res.mag, 1'b1}),
        .b     (step_reg),
        .res   (d_res)
    );

    // next step = (scale[m] * step) >> 8
    a4e_mul u_mul_step (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_res.done),
        .a     (a4e_pkg::step_scale(q_res.mag)),
        .b     (step_reg),
        .res   (s_res)
    );

    // predictor / step update and byte packing
    always_comb
    begin
        code   = {sign_reg, m_reg};
        d_raw  = d_res.product[18:3];
        d_cl   = d_raw[15] ? 15'h7fff : d_raw[14:0];
        if (sign_reg)
            nv = {pred_reg[a4e_pkg::PRED_W-1], pred_reg} - {2'b00, d_cl};
        else
            nv = {pred_reg[a4e_pkg::PRED_W-1], pred_reg} + {2'b00, d_cl};
        // 17-bit result out of 16-bit range when the top two bits differ
        if (nv[a4e_pkg::PRED_W] != nv[a4e_pkg::PRED_W-1])
            nv_cl = nv[a4e_pkg::PRED_W] ? 16'h8000 : 16'h7fff;
        else
            nv_cl = nv[a4e_pkg::PRED_W-1:0];
        ns_raw = s_res.product[24:8];
        if (ns_raw < {2'b00, a4e_pkg::STEP_MIN})
            ns_cl = a4e_pkg::STEP_MIN;
        else if (ns_raw > {2'b00, a4e_pkg::STEP_MAX})
            ns_cl = a4e_pkg::STEP_MAX;
        else
            ns_cl = ns_raw[a4e_pkg::STEP_W-1:0];
        upd_byte = phase_reg ? {code, held_reg} : {4'b0000, code};
        upd_need = phase_reg || last_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        pred_next     = pred_reg;
        step_next     = step_reg;
        held_next     = held_reg;
        phase_next    = phase_reg;
        res_byte_next = res_byte_reg;
        res_end_next  = res_end_reg;
        out_byte_next = res_byte_reg;
        out_end_next  = res_end_reg;
        load_out      = 1'b0;
        q_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pcm.valid)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_QLOAD;
            end
            ST_QLOAD:
            begin
                q_start    = 1'b1;
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                if (q_res.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (d_res.done)
                begin
                    res_byte_next = upd_byte;
                    res_end_next  = last_reg;
                    out_byte_next = upd_byte;
                    out_end_next  = last_reg;
                    if (last_reg)
                    begin
                        pred_next  = '0;
                        step_next  = a4e_pkg::STEP_MIN;
                        held_next  = '0;
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        pred_next  = nv_cl;
                        step_next  = ns_cl;
                        held_next  = phase_reg ? held_reg : code;
                        phase_next = !phase_reg;
                    end
                    if (!upd_need)
                        state_next = ST_IDLE;
                    else if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pred_reg      <= '0;
            step_reg      <= a4e_pkg::STEP_MIN;
            held_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pred_reg  <= pred_next;
            step_reg  <= step_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (adpcm.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= pcm.sample;
            last_reg   <= pcm.last;
        end
        if (state_reg == ST_DIFF)
        begin
            sign_reg <= diff[a4e_pkg::SAMPLE_W];
            mag_reg  <= diff[a4e_pkg::SAMPLE_W] ? diff_neg[a4e_pkg::MAG_W-1:0]
                                                : diff[a4e_pkg::MAG_W-1:0];
        end
        if (q_res.done)
            m_reg <= q_res.mag;
        res_byte_reg <= res_byte_next;
        res_end_reg  <= res_end_next;
        if (load_out)
        begin
            out_byte_reg <= out_byte_next;
            out_end_reg  <= out_end_next;
        end
    end

    // one item in flight: no new item right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !pcm.ready)
        else $error("input accepted while an item is in flight");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg >= a4e_pkg::STEP_MIN) && (step_reg <= a4e_pkg::STEP_MAX))
        else $error("step size out of range");

    a_mul_sync: assert property (@(posedge clk) disable iff (!rst_n)
        d_res.done == s_res.done)
        else $error("multipliers out of step");

    a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        d_res.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its state");

    a_quant_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_res.done |-> (state_reg == ST_QUANT))
        else $error("quotient finished outside its state");

endmodule
`default_nettype wire

@@ hw/rtl/a4e_quant.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a4e_quant
// Bit-serial quotient unit: min(7, floor(4*mag/step)), one quotient bit per
// cycle by restoring compare-subtract.
// ----------------------------------------------------------------------------
module a4e_quant (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [a4e_pkg::MAG_W-1:0]     mag,
    input  wire logic [a4e_pkg::STEP_W-1:0]    step,
    output a4e_pkg::quant_res_t                res
);

    logic [a4e_pkg::MAG_W-1:0]  rem_reg;
    logic [a4e_pkg::MAG_W-1:0]  rem_next;
    logic [a4e_pkg::MAG_W-1:0]  rem_sub;
    logic [a4e_pkg::MAG_W-1:0]  rem_sel;
    logic [2:0]                 q_reg;
    logic                       sat_reg;
    logic                       sat_start;
    logic                       ge;
    logic [a4e_pkg::QCNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    // saturate when 4*mag >= 8*step
    assign sat_start = {1'b0, mag} >= {1'b0, step, 1'b0};

    assign ge       = rem_reg >= {1'b0, step};
    assign rem_sub  = rem_reg - {1'b0, step};
    assign rem_sel  = ge ? rem_sub : rem_reg;
    assign rem_next = {rem_sel[a4e_pkg::MAG_W-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == a4e_pkg::QCNT_W'(a4e_pkg::QUANT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag;
            sat_reg <= sat_start;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[1:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.mag  = sat_reg ? 3'd7 : q_reg;

endmodule
`default_nettype wire

@@ hw/rtl/a4e_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// a4e_mul
// Radix-4 shift-add multiplier: two multiplier bits retired per cycle.
// ----------------------------------------------------------------------------
module a4e_mul (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [a4e_pkg::MUL_A_W-1:0]    a,
    input  wire logic [a4e_pkg::MUL_B_W-1:0]    b,
    output a4e_pkg::mul_res_t                   res
);

    logic [a4e_pkg::MUL_A_W-1:0] a_reg;
    logic [a4e_pkg::MUL_P_W-1:0] mcand_reg;
    logic [a4e_pkg::MUL_P_W-1:0] acc_reg;
    logic [a4e_pkg::MUL_P_W-1:0] pp;
    logic [a4e_pkg::MCNT_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    assign pp = (a_reg[0] ? mcand_reg : '0)
              + (a_reg[1] ? {mcand_reg[a4e_pkg::MUL_P_W-2:0], 1'b0} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == a4e_pkg::MCNT_W'(a4e_pkg::MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg     <= a;
            mcand_reg <= {{a4e_pkg::MUL_A_W{1'b0}}, b};
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            a_reg     <= {2'b00, a_reg[a4e_pkg::MUL_A_W-1:2]};
            mcand_reg <= {mcand_reg[a4e_pkg::MUL_P_W-3:0], 2'b00};
            acc_reg   <= acc_reg + pp;
        end
    end

    assign res.done    = done_reg;
    assign res.product = acc_reg;

endmodule
`default_nettype wire
